### design/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, register indexes and fixed-point helpers for the PID step.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 24;
  localparam int unsigned ThrW  = 31;
  localparam int unsigned AddrW = 3;
  // wide enough for every difference, sum and shifted product before saturation
  localparam int unsigned WideW = 41;
  localparam int unsigned ProdW = 57;

  localparam logic [AddrW-1:0] RegPropGain  = 3'd0;
  localparam logic [AddrW-1:0] RegIntegGain = 3'd1;
  localparam logic [AddrW-1:0] RegDerivGain = 3'd2;
  localparam logic [AddrW-1:0] RegLawMode   = 3'd3;
  localparam logic [AddrW-1:0] RegUpperLim  = 3'd4;
  localparam logic [AddrW-1:0] RegLowerLim  = 3'd5;
  localparam logic [AddrW-1:0] RegSepThr    = 3'd6;

  localparam logic LawIncremental = 1'b0;
  localparam logic LawPositional  = 1'b1;

  localparam logic signed [GainW-1:0] PropGainRst  = 24'sd13107;
  localparam logic signed [GainW-1:0] IntegGainRst = 24'sd983;
  localparam logic signed [GainW-1:0] DerivGainRst = 24'sd13107;
  localparam logic signed [DataW-1:0] UpperLimRst  = 32'sd26214400;
  localparam logic signed [DataW-1:0] LowerLimRst  = -32'sd13107200;
  localparam logic        [ThrW-1:0]  SepThrRst    = 31'd13107200;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic                    law_mode;
    logic signed [DataW-1:0] upper_limit;
    logic signed [DataW-1:0] lower_limit;
    logic        [ThrW-1:0]  separation_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] output_value;
    logic signed [DataW-1:0] error_prev;
    logic signed [DataW-1:0] error_prev_prev;
    logic signed [DataW-1:0] integral_sum;
  } state_t;

  function automatic logic signed [WideW-1:0] sext_wide(input logic signed [DataW-1:0] v);
    return {{(WideW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] max_v;
    logic signed [WideW-1:0] min_v;
    max_v = {{(WideW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    min_v = {{(WideW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
    if (v > max_v) begin
      return max_v[DataW-1:0];
    end else if (v < min_v) begin
      return min_v[DataW-1:0];
    end else begin
      return v[DataW-1:0];
    end
  endfunction

  // q8.16 gain times q16.16 value, round half up, back to q16.16
  function automatic logic signed [DataW-1:0] gain_mul(
    input logic signed [GainW-1:0] gain,
    input logic signed [DataW-1:0] val
  );
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] gain_x;
    logic signed [ProdW-1:0] val_x;
    gain_x = {{(ProdW-GainW){gain[GainW-1]}}, gain};
    val_x  = {{(ProdW-DataW){val[DataW-1]}}, val};
    prod   = gain_x * val_x + ProdW'(32768);
    return sat32($signed(prod[ProdW-1:16]));
  endfunction

endpackage

### design/pid_controller_step.sv
// ----------------------------------------------------------------------------
// pid_controller_step
// Fixed-point incremental / positional PID controller, one update per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one setpoint per transaction (q16.16 in tdata); m_axis
//   returns the new drive value (q16.16, saturated) for every setpoint, in
//   order. Gains, law, limits and separation threshold are set through the
//   cfg write port while no sample is in flight.
// Pipeline and throughput:
//   a setpoint is registered on acceptance, the control law is evaluated
//   from that register and the held state in the next cycle, and the drive
//   value is registered into the output register. With m_axis_tready high,
//   one transaction per cycle is sustained: the output register and the held
//   state update in the same cycle, so the next sample sees the new state.
// Reset:
//   rst_ni clears the output value, error history and integral sum to zero
//   and loads the register defaults; both channels come up empty.
// Stall:
//   while m_axis_tready is low the result holds; an empty input register still
//   takes one more setpoint, then s_axis_tready drops until the result goes.
// ----------------------------------------------------------------------------
module pid_controller_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [pid_pkg::AddrW-1:0]     cfg_addr_i,
  input  logic [pid_pkg::DataW-1:0]     cfg_wdata_i,
  // setpoint stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pid_pkg::DataW-1:0]     s_axis_tdata,   // [31:0] setpoint
  // drive value stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pid_pkg::DataW-1:0]     m_axis_tdata    // [31:0] drive_value
);
  import pid_pkg::*;

  cfg_t                    cfg;
  state_t                  state_q;
  state_t                  state_d;
  logic                    in_valid_q;
  logic signed [DataW-1:0] setpoint_q;
  logic                    res_valid_q;
  logic [DataW-1:0]        drive_value_q;
  logic                    advance;

  pid_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pid_law u_law (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .setpoint_i (setpoint_q),
    .state_o    (state_d)
  );

  // result register can take a new value
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      setpoint_q <= s_axis_tdata;
    end
    if (advance && in_valid_q) begin
      drive_value_q <= state_d.output_value;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = drive_value_q;

endmodule

### design/pid_cfg_regs.sv
// ----------------------------------------------------------------------------
// pid_cfg_regs
// Write-only configuration registers for the PID step.
// ----------------------------------------------------------------------------
module pid_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [pid_pkg::AddrW-1:0] cfg_addr_i,
  input  logic [pid_pkg::DataW-1:0] cfg_wdata_i,
  output pid_pkg::cfg_t         cfg_o
);
  import pid_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegPropGain:  cfg_d.prop_gain            = cfg_wdata_i[GainW-1:0];
        RegIntegGain: cfg_d.integ_gain           = cfg_wdata_i[GainW-1:0];
        RegDerivGain: cfg_d.deriv_gain           = cfg_wdata_i[GainW-1:0];
        RegLawMode:   cfg_d.law_mode             = cfg_wdata_i[0];
        RegUpperLim:  cfg_d.upper_limit          = cfg_wdata_i;
        RegLowerLim:  cfg_d.lower_limit          = cfg_wdata_i;
        RegSepThr:    cfg_d.separation_threshold = cfg_wdata_i[ThrW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain            <= PropGainRst;
      cfg_q.integ_gain           <= IntegGainRst;
      cfg_q.deriv_gain           <= DerivGainRst;
      cfg_q.law_mode             <= LawIncremental;
      cfg_q.upper_limit          <= UpperLimRst;
      cfg_q.lower_limit          <= LowerLimRst;
      cfg_q.separation_threshold <= SepThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pid_law.sv
// ----------------------------------------------------------------------------
// pid_law
// Control law datapath: next controller state from setpoint and current state.
// ----------------------------------------------------------------------------
module pid_law (
  input  pid_pkg::cfg_t                    cfg_i,
  input  pid_pkg::state_t                  state_i,
  input  logic signed [pid_pkg::DataW-1:0] setpoint_i,
  output pid_pkg::state_t                  state_o
);
  import pid_pkg::*;

  logic signed [DataW-1:0] err;
  logic signed [DataW-1:0] d1;
  logic signed [DataW-1:0] d2;
  logic signed [WideW-1:0] mag;
  logic                    sep;
  logic                    add_int;
  logic signed [DataW-1:0] sum_upd;
  logic signed [DataW-1:0] sum_new;
  logic signed [DataW-1:0] p_in;
  logic signed [DataW-1:0] i_in;
  logic signed [DataW-1:0] d_in;
  logic signed [DataW-1:0] p_term;
  logic signed [DataW-1:0] i_term;
  logic signed [DataW-1:0] d_term;
  logic signed [DataW-1:0] acc;
  logic signed [DataW-1:0] out_inc;
  logic                    positional;

  assign positional = (cfg_i.law_mode == LawPositional);

  assign err = sat32(sext_wide(setpoint_i) - sext_wide(state_i.output_value));
  assign d1  = sat32(sext_wide(err) - sext_wide(state_i.error_prev));
  assign d2  = sat32(sext_wide(err) - (sext_wide(state_i.error_prev) <<< 1)
                     + sext_wide(state_i.error_prev_prev));

  // integral separation and anti-windup
  assign mag = err[DataW-1] ? -sext_wide(err) : sext_wide(err);
  assign sep = mag > $signed({{(WideW-ThrW){1'b0}}, cfg_i.separation_threshold});

  always_comb begin
    if (state_i.output_value > cfg_i.upper_limit) begin
      add_int = !sep && err[DataW-1];
    end else if (state_i.output_value < cfg_i.lower_limit) begin
      add_int = !sep && !err[DataW-1] && (err != '0);
    end else begin
      add_int = !sep;
    end
  end

  assign sum_upd = sat32(sext_wide(state_i.integral_sum) + sext_wide(err));
  assign sum_new = (positional && add_int) ? sum_upd : state_i.integral_sum;

  // the three gain multipliers are shared by both laws
  assign p_in = positional ? err     : d1;
  assign i_in = positional ? sum_new : err;
  assign d_in = positional ? d1      : d2;

  assign p_term = gain_mul(cfg_i.prop_gain, p_in);
  assign i_term = (positional && sep) ? '0 : gain_mul(cfg_i.integ_gain, i_in);
  assign d_term = gain_mul(cfg_i.deriv_gain, d_in);

  assign acc     = sat32(sext_wide(p_term) + sext_wide(i_term) + sext_wide(d_term));
  assign out_inc = sat32(sext_wide(state_i.output_value) + sext_wide(acc));

  assign state_o.output_value    = positional ? acc : out_inc;
  assign state_o.error_prev      = err;
  assign state_o.error_prev_prev = state_i.error_prev;
  assign state_o.integral_sum    = sum_new;

endmodule

### tb/tb_pid_controller_step.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_step
// Self-checking bench for the fixed-point PID step: a directed table covering
// reset, saturation, both control laws, integral separation, crossed limits
// and gain extremes, then randomized phases with new register settings and
// setpoint runs. Each drive value is checked against an in-bench controller
// model or a fixed table value; source and sink are throttled in most phases.
// ----------------------------------------------------------------------------
module tb_pid_controller_step;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_pkg::*;

  // address with no register behind it, writes must be dropped
  localparam logic [AddrW-1:0] RegNone = 3'd7;

  localparam int RowCount   = 36;
  localparam int PhaseCount = 9;
  localparam int PhaseItems = 170;
  localparam int HoldCycles = 96;
  localparam int DrainLimit = 4000;

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -WordMax - 1;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  value;
    logic              typed;
    logic [DataW-1:0]  drive;
  } stim_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [AddrW-1:0]  cfg_addr_i    = '0;
  logic [DataW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata  = '0;  // [31:0] setpoint
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DataW-1:0]  m_axis_tdata;        // [31:0] drive_value

  pid_controller_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // controller copy: register settings and held state
  logic signed [GainW-1:0] kp       = PropGainRst;
  logic signed [GainW-1:0] ki       = IntegGainRst;
  logic signed [GainW-1:0] kd       = DerivGainRst;
  logic                    law      = LawIncremental;
  logic signed [DataW-1:0] umax     = UpperLimRst;
  logic signed [DataW-1:0] umin     = LowerLimRst;
  logic        [ThrW-1:0]  sep_thr  = SepThrRst;
  logic signed [DataW-1:0] drive_now  = '0;
  logic signed [DataW-1:0] err_recent = '0;
  logic signed [DataW-1:0] err_older  = '0;
  logic signed [DataW-1:0] integ_acc  = '0;

  logic [DataW-1:0] drive_expect_q[$];
  int               mismatch_count = 0;
  int               send_idle_pct  = 0;
  int               recv_idle_pct  = 0;
  int               hold_req       = 0;
  bit               stream_busy    = 1'b0;
  logic signed [DataW-1:0] aim     = '0;

  stim_row_t directed_rows [RowCount] = '{
    '{RowSample, RegNone,      32'h0000_0000, 1'b1, 32'h0000_0000}, // zero error from reset
    '{RowSample, RegNone,      32'h0001_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h7FFF_FFFF, 1'b0, '0},
    '{RowSample, RegNone,      32'h8000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h7FFF_FFFF, 1'b0, '0},
    '{RowSample, RegNone,      32'hFFFF_FFFF, 1'b0, '0},
    '{RowWrite,  RegNone,      32'hFFFF_FFFF, 1'b0, '0},
    '{RowWrite,  RegLawMode,   {31'b0, LawPositional}, 1'b0, '0},
    '{RowSample, RegNone,      32'h0064_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h0100_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h7FFF_FFFF, 1'b0, '0},
    '{RowSample, RegNone,      32'h8000_0000, 1'b0, '0},
    // lower above upper
    '{RowWrite,  RegUpperLim,  32'hFFF0_0000, 1'b0, '0},
    '{RowWrite,  RegLowerLim,  32'h0010_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h0005_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'hFFFB_0000, 1'b0, '0},
    '{RowWrite,  RegSepThr,    32'hFFFF_FFFF, 1'b0, '0},
    '{RowSample, RegNone,      32'h8000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h7FFF_FFFF, 1'b0, '0},
    '{RowWrite,  RegSepThr,    32'h0000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h0001_0000, 1'b0, '0},
    '{RowWrite,  RegPropGain,  32'hFF7F_FFFF, 1'b0, '0},
    '{RowWrite,  RegIntegGain, 32'h0080_0000, 1'b0, '0},
    '{RowWrite,  RegDerivGain, 32'h007F_FFFF, 1'b0, '0},
    '{RowWrite,  RegSepThr,    32'h7FFF_FFFF, 1'b0, '0},
    '{RowWrite,  RegUpperLim,  32'h7FFF_FFFF, 1'b0, '0},
    '{RowWrite,  RegLowerLim,  32'h8000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h4000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'hC000_0000, 1'b0, '0},
    '{RowSample, RegNone,      32'h0000_0001, 1'b0, '0},
    '{RowWrite,  RegPropGain,  32'h0000_0000, 1'b0, '0},
    '{RowWrite,  RegIntegGain, 32'h0000_0000, 1'b0, '0},
    '{RowWrite,  RegDerivGain, 32'h0000_0000, 1'b0, '0},
    // zero gains: positional output is zero
    '{RowSample, RegNone,      32'h1234_5678, 1'b1, 32'h0000_0000},
    '{RowWrite,  RegLawMode,   {31'b0, LawIncremental}, 1'b0, '0},
    // zero gains: incremental output holds at zero
    '{RowSample, RegNone,      32'hEDCB_A987, 1'b1, 32'h0000_0000}
  };

  function automatic logic signed [DataW-1:0] clamp_word(input longint v);
    if (v > WordMax) return 32'sh7FFF_FFFF;
    if (v < WordMin) return 32'sh8000_0000;
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] scale_by_gain(
    input logic signed [GainW-1:0] g,
    input logic signed [DataW-1:0] v
  );
    longint p;
    p = longint'(g) * longint'(v) + 64'sd32768;
    return clamp_word(p >>> 16);
  endfunction

  // one control step on the bench copy, returns the new drive value
  function automatic logic [DataW-1:0] advance_controller(input logic signed [DataW-1:0] sp);
    logic signed [DataW-1:0] e;
    logic signed [DataW-1:0] d1;
    logic signed [DataW-1:0] d2;
    longint                  acc;
    longint                  mag;
    bit                      sep;
    bit                      accumulate;
    e = clamp_word(longint'(sp) - longint'(drive_now));
    if (law == LawIncremental) begin
      d1  = clamp_word(longint'(e) - longint'(err_recent));
      d2  = clamp_word(longint'(e) - 2 * longint'(err_recent) + longint'(err_older));
      acc = longint'(scale_by_gain(kp, d1)) + longint'(scale_by_gain(ki, e))
          + longint'(scale_by_gain(kd, d2));
      drive_now = clamp_word(longint'(drive_now) + longint'(clamp_word(acc)));
    end else begin
      mag = (e < 0) ? -longint'(e) : longint'(e);
      sep = mag > longint'(sep_thr);
      // anti-windup: upper test wins when limits are crossed
      if (drive_now > umax) begin
        accumulate = !sep && (e < 0);
      end else if (drive_now < umin) begin
        accumulate = !sep && (e > 0);
      end else begin
        accumulate = !sep;
      end
      if (accumulate) integ_acc = clamp_word(longint'(integ_acc) + longint'(e));
      acc = longint'(scale_by_gain(kp, e))
          + (sep ? 64'sd0 : longint'(scale_by_gain(ki, integ_acc)))
          + longint'(scale_by_gain(kd, clamp_word(longint'(e) - longint'(err_recent))));
      drive_now = clamp_word(acc);
    end
    err_older  = err_recent;
    err_recent = e;
    return drive_now;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t ns: %s: drive_value got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // register write, only once the pipeline has emptied
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    if (stream_busy) begin
      s_axis_tvalid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      stream_busy = 1'b0;
    end
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      RegPropGain:  kp      = data[GainW-1:0];
      RegIntegGain: ki      = data[GainW-1:0];
      RegDerivGain: kd      = data[GainW-1:0];
      RegLawMode:   law     = data[0];
      RegUpperLim:  umax    = data;
      RegLowerLim:  umin    = data;
      RegSepThr:    sep_thr = data[ThrW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [DataW-1:0] sp, input logic typed,
                             input logic [DataW-1:0] typed_drive);
    logic [DataW-1:0] predicted;
    cfg_we_i   <= 1'b0;
    stream_busy = 1'b1;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sp;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_controller(sp);
    drive_expect_q.push_back(typed ? typed_drive : predicted);
  endtask

  function automatic logic [DataW-1:0] pick_gain_word();
    logic [GainW-1:0] g;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       g = 24'h7F_FFFF;
          1:       g = 24'h80_0000;
          2:       g = '0;
          default: g = 24'hFF_FFFF;
        endcase
      end
      1: g = 24'($urandom);
      default: begin
        g = 24'($urandom_range(0, 98304));
        if ($urandom_range(0, 3) == 0) g = -g;
      end
    endcase
    return {8'($urandom), g};
  endfunction

  function automatic logic [DataW-1:0] pick_limit(input bit upper_side);
    logic [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: v = $urandom;
      default: begin
        v = 32'($urandom_range(0, 32'h0400_0000));
        // occasionally on the wrong side so the limits cross
        if (upper_side == ($urandom_range(0, 7) == 0)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [DataW-1:0] pick_threshold();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = 32'h7FFF_FFFF;
      2: v = $urandom;
      default: v = 32'($urandom_range(0, 32'h0400_0000));
    endcase
    v[DataW-1] = 1'($urandom);
    return v;
  endfunction

  // mostly runs toward a held target, with jumps and full-range noise
  function automatic logic [DataW-1:0] pick_setpoint();
    int unsigned r;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 24) == 0) begin
      aim = $urandom_range(0, 3) == 0 ? 32'($urandom)
          : 32'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    end
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (r <= 3) begin
      return $urandom;
    end else if (r <= 7) begin
      return 32'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    end
    return aim + 32'($urandom_range(0, 2048)) - 32'sd1024;
  endfunction

  // sink: throttles tready, runs long hold-offs on request, checks results
  initial begin
    int hold_left;
    logic [DataW-1:0] want;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, 'x);
        end else begin
          want = drive_expect_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("wrong drive_value", m_axis_tdata, want);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req > 0) begin
        hold_left = hold_req - 1;
        hold_req  = 0;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 54;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].drive);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(RegPropGain, pick_gain_word());
      write_reg(RegIntegGain, pick_gain_word());
      write_reg(RegDerivGain, pick_gain_word());
      write_reg(RegLawMode, {31'($urandom), 1'(ph % 2)});
      write_reg(RegUpperLim, pick_limit(1'b1));
      write_reg(RegLowerLim, pick_limit(1'b0));
      write_reg(RegSepThr, pick_threshold());
      if ($urandom_range(0, 2) == 0) write_reg(RegNone, $urandom);
      // sink stalls for a long stretch while the source keeps offering
      if (ph == 6) hold_req = HoldCycles;
      for (int n = 0; n < PhaseItems; n++) begin
        send_sample(pick_setpoint(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (drive_expect_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    while (drive_expect_q.size() != 0) begin
      report_mismatch("missing transaction", 'x, drive_expect_q.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
design/pid_pkg.sv
design/pid_cfg_regs.sv
design/pid_law.sv
design/pid_controller_step.sv
tb/tb_pid_controller_step.sv
